// ===== rtl/core/epws_pkg.sv =====
// Shared types, codes and defaults for the EEPROM page write splitter.
package epws_pkg;

    localparam int PAGE_BYTES_DEF = 64;
    localparam int MEM_BYTES_DEF  = 32768;

    localparam logic [7:0] WRITE_CYCLE_MS_RST = 8'd5;

    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 56;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_OUTCOME = 2'd1,
        REQ_POLL    = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        WM_BYTE = 2'd0,
        WM_PAGE = 2'd1,
        WM_BUF  = 2'd2
    } wmode_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_BUSY  = 2'd1,
        STS_ERROR = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_SENDING = 3'd1,
        ST_SENT    = 3'd2,
        ST_WAITING = 3'd3,
        ST_DONE    = 3'd4,
        ST_NACK    = 3'd5
    } state_t;

    typedef struct packed {
        req_t        req_type;
        logic [1:0]  write_mode;
        logic [15:0] start_addr;
        logic [15:0] length;
        logic [7:0]  data_byte;
        logic        burst_nack;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        status_t     status;
        state_t      ctl_state;
        logic        burst_valid;
        logic [14:0] burst_addr;
        logic [6:0]  burst_len;
        logic [14:0] burst_offset;
        logic [7:0]  single_data;
    } result_t;

endpackage

// ===== rtl/core/epws_page_mod.sv =====
// Offset of an address within its page, from two constant remainder tables.
module epws_page_mod
    import epws_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    localparam int OFF_W = $clog2(PAGE_BYTES)
)
(
    input  logic [15:0]      addr,
    output logic [OFF_W-1:0] page_off
);

    logic [OFF_W-1:0] hi_tbl [256];
    logic [OFF_W-1:0] lo_tbl [256];
    logic [OFF_W:0]   part_sum;

    for (genvar g = 0; g < 256; g++)
    begin : g_tbl
        assign hi_tbl[g] = OFF_W'((g * 256) % PAGE_BYTES);
        assign lo_tbl[g] = OFF_W'(g % PAGE_BYTES);
    end

    // Both partial remainders are below one page, so one subtract finishes it.
    assign part_sum = {1'b0, hi_tbl[addr[15:8]]} + {1'b0, lo_tbl[addr[7:0]]};

    always_comb
    begin
        if (part_sum >= (OFF_W+1)'(PAGE_BYTES))
        begin
            page_off = OFF_W'(part_sum - (OFF_W+1)'(PAGE_BYTES));
        end
        else
        begin
            page_off = OFF_W'(part_sum);
        end
    end

endmodule

// ===== rtl/core/epws_in_stage.sv =====
// Input register: takes one stream transaction and holds the unpacked item.
module epws_in_stage
    import epws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]          s_axis_tuser,
    output logic                item_valid,
    output item_t               item,
    input  logic                item_take
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    assign s_axis_tready = !valid_reg || item_take;

    always_comb
    begin
        item_next.req_type   = req_t'(s_axis_tuser);
        item_next.write_mode = s_axis_tdata[1:0];
        item_next.start_addr = s_axis_tdata[17:2];
        item_next.length     = s_axis_tdata[33:18];
        item_next.data_byte  = s_axis_tdata[41:34];
        item_next.burst_nack = s_axis_tdata[42];
        item_next.now_ms     = s_axis_tdata[74:43];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/epws_ctrl.sv =====
// Write request checks, burst splitting state machine and result register.
module epws_ctrl
    import epws_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int MEM_BYTES  = MEM_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  item_t      item,
    output logic       item_take,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res
);

    localparam int OFF_W = $clog2(PAGE_BYTES);
    localparam int PG_W  = $clog2(PAGE_BYTES + 1);
    localparam logic [16:0]     MEM_LIM  = 17'(MEM_BYTES);
    localparam logic [16:0]     PAGE_LIM = 17'(PAGE_BYTES);
    localparam logic [PG_W-1:0] PAGE_LEN = PG_W'(PAGE_BYTES);

    state_t          state_reg, state_next;
    logic [15:0]     base_addr_reg, base_addr_next;
    logic [15:0]     total_bytes_reg, total_bytes_next;
    logic [15:0]     bytes_done_reg, bytes_done_next;
    logic [PG_W-1:0] cur_page_len_reg, cur_page_len_next;
    logic [31:0]     wait_start_reg, wait_start_next;
    logic [7:0]      held_byte_reg, held_byte_next;
    logic [7:0]      write_cycle_ms_reg;
    logic            res_valid_reg;
    result_t         res_reg, res_next;

    logic             advance;
    logic [OFF_W-1:0] page_off;
    logic [16:0]      addr_ext, len_ext, off_ext;
    logic             is_write, is_outcome, is_poll, is_clear;
    logic             mode_bad, page_bad, buf_bad, req_bad;
    logic             wr_ok, expired, more, issue;
    logic [31:0]      elapsed;
    logic [15:0]      len_eff, done_sum;
    logic [15:0]      iss_base, iss_total, iss_done, iss_remain, iss_addr;
    logic [PG_W-1:0]  iss_room, iss_len;

    assign advance   = item_valid && (!res_valid_reg || res_ready);
    assign item_take = advance;
    assign cfg_ready = 1'b1;

    epws_page_mod #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_page_mod (
        .addr     (item.start_addr),
        .page_off (page_off)
    );

    assign is_write   = (item.req_type == REQ_WRITE);
    assign is_outcome = (item.req_type == REQ_OUTCOME);
    assign is_poll    = (item.req_type == REQ_POLL);
    assign is_clear   = (item.req_type == REQ_CLEAR);

    assign addr_ext = {1'b0, item.start_addr};
    assign len_ext  = {1'b0, item.length};
    assign off_ext  = 17'(page_off);

    assign mode_bad = (item.write_mode != WM_BYTE) && (item.write_mode != WM_PAGE)
                   && (item.write_mode != WM_BUF);
    // A span that stays inside the page also keeps the length within a page.
    assign page_bad = (item.length == 16'd0) || (off_ext + len_ext > PAGE_LIM);
    assign buf_bad  = (item.length == 16'd0) || (addr_ext + len_ext > MEM_LIM);
    assign req_bad  = mode_bad || (addr_ext >= MEM_LIM)
                   || ((item.write_mode == WM_PAGE) && page_bad)
                   || ((item.write_mode == WM_BUF) && buf_bad);

    assign wr_ok   = is_write && (state_reg == ST_IDLE) && !req_bad;
    assign elapsed = item.now_ms - wait_start_reg;
    assign expired = is_poll && (state_reg == ST_WAITING)
                  && (elapsed >= {24'd0, write_cycle_ms_reg});

    assign done_sum = bytes_done_reg + 16'(cur_page_len_reg);
    assign more     = (done_sum < total_bytes_reg);
    assign issue    = wr_ok || (expired && more);

    assign len_eff = (item.write_mode == WM_BYTE) ? 16'd1 : item.length;

    // Every burst after the first starts on a page boundary: a full page of room.
    assign iss_base   = wr_ok ? item.start_addr : base_addr_reg;
    assign iss_total  = wr_ok ? len_eff : total_bytes_reg;
    assign iss_done   = wr_ok ? 16'd0 : done_sum;
    assign iss_room   = wr_ok ? (PAGE_LEN - PG_W'(page_off)) : PAGE_LEN;
    assign iss_remain = iss_total - iss_done;
    assign iss_addr   = iss_base + iss_done;
    assign iss_len    = (iss_remain < 16'(iss_room)) ? PG_W'(iss_remain) : iss_room;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (wr_ok)
                begin
                    state_next = ST_SENDING;
                end
            end
            ST_SENDING:
            begin
                if (is_outcome)
                begin
                    state_next = item.burst_nack ? ST_NACK : ST_SENT;
                end
            end
            ST_SENT:
            begin
                if (is_poll)
                begin
                    state_next = ST_WAITING;
                end
            end
            ST_WAITING:
            begin
                if (expired)
                begin
                    state_next = more ? ST_SENDING : ST_DONE;
                end
            end
            ST_DONE, ST_NACK:
            begin
                if (is_clear)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        base_addr_next    = base_addr_reg;
        total_bytes_next  = total_bytes_reg;
        bytes_done_next   = bytes_done_reg;
        cur_page_len_next = cur_page_len_reg;
        wait_start_next   = wait_start_reg;
        held_byte_next    = held_byte_reg;
        res_next          = '0;

        if (is_write)
        begin
            priority if (state_reg != ST_IDLE)
            begin
                res_next.status = STS_BUSY;
            end
            else if (req_bad)
            begin
                res_next.status = STS_ERROR;
            end
            else
            begin
                res_next.status = STS_OK;
            end
        end

        if (wr_ok)
        begin
            base_addr_next   = item.start_addr;
            total_bytes_next = len_eff;
            held_byte_next   = (item.write_mode == WM_BYTE) ? item.data_byte : 8'd0;
        end

        if (expired)
        begin
            bytes_done_next = done_sum;
        end

        if (is_poll && (state_reg == ST_SENT))
        begin
            wait_start_next = item.now_ms;
        end

        if (issue)
        begin
            bytes_done_next          = iss_done;
            cur_page_len_next        = iss_len;
            res_next.burst_valid     = 1'b1;
            res_next.burst_addr      = iss_addr[14:0];
            res_next.burst_len       = 7'(iss_len);
            res_next.burst_offset    = iss_done[14:0];
            res_next.single_data     = held_byte_next;
        end

        res_next.ctl_state = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            base_addr_reg    <= '0;
            total_bytes_reg  <= '0;
            bytes_done_reg   <= '0;
            cur_page_len_reg <= '0;
            wait_start_reg   <= '0;
            held_byte_reg    <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg        <= state_next;
                base_addr_reg    <= base_addr_next;
                total_bytes_reg  <= total_bytes_next;
                bytes_done_reg   <= bytes_done_next;
                cur_page_len_reg <= cur_page_len_next;
                wait_start_reg   <= wait_start_next;
                held_byte_reg    <= held_byte_next;
                res_valid_reg    <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_cycle_ms_reg <= WRITE_CYCLE_MS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            write_cycle_ms_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_burst_means_sending: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.burst_valid |-> res_reg.ctl_state == ST_SENDING)
        else $error("burst issued without entering sending state");

    a_no_burst_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_reg.status != STS_OK) |-> !res_reg.burst_valid)
        else $error("burst issued on a rejected write request");

    a_page_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SENDING |->
            (cur_page_len_reg != '0) && (cur_page_len_reg <= PAGE_LEN))
        else $error("burst length outside one page");

    a_progress_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SENDING || state_reg == ST_SENT || state_reg == ST_WAITING)
            |-> bytes_done_reg < total_bytes_reg)
        else $error("bytes done reached total while a burst is open");

endmodule

// ===== rtl/core/eeprom_page_write_splitter_top.sv =====
// Top level of the EEPROM page write splitter.
//
// Channels: s_axis carries one request per transaction (write request, burst
// outcome, task poll or clear, selected by s_axis_tuser). m_axis returns
// exactly one result transaction per request: the write answer, the control
// state after the request and, when issued, one page burst command.
// cfg_valid/cfg_data load write_cycle_ms; cfg_ready is always high.
//
// A request goes through the input register, then the result register, to m_axis.
// Throughput: one request per cycle while m_axis_tready is high; both registers
// advance together, and the input register refills in the same cycle that its
// item moves on.
//
// Reset: the machine returns to idle with all burst bookkeeping cleared and
// write_cycle_ms set to 5; both channels come up empty.
// Stall: while m_axis_tready is low the result holds, the input register
// still takes one more request, and s_axis_tready then drops until the
// result is taken.
module eeprom_page_write_splitter_top
    import epws_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int MEM_BYTES  = MEM_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // write_mode[1:0], start_addr[17:2], length[33:18], data_byte[41:34],
    // burst_nack[42], now_ms[74:43], zero fill above
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // status[1:0], ctl_state[4:2], burst_addr[19:5], burst_len[26:20],
    // burst_offset[41:27], single_data[49:42], zero fill above
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // burst_valid[0]
    output logic [0:0]          m_axis_tuser,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    logic    item_valid;
    item_t   item;
    logic    item_take;
    result_t res;

    epws_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take)
    );

    epws_ctrl #(
        .PAGE_BYTES (PAGE_BYTES),
        .MEM_BYTES  (MEM_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tdata = {6'd0, res.single_data, res.burst_offset, res.burst_len,
                           res.burst_addr, res.ctl_state, res.status};
    assign m_axis_tuser = res.burst_valid;

endmodule
